### src/osf_pkg.sv
// Shared types, widths and codes for the ordered store with overflow queue.
`default_nettype none
package osf_pkg;

  localparam int unsigned DEF_STORE_DEPTH = 64;
  localparam int unsigned DEF_RING_DEPTH  = 64;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SCOUNT_W    = 7;
  localparam int unsigned WCOUNT_W    = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [CFG_DATA_W-1:0] RST_LOT_CAPACITY = CFG_DATA_W'(64);
  localparam logic [CFG_DATA_W-1:0] RST_RING_SIZE    = CFG_DATA_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_LOT_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE    = CFG_IDX_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ARRIVE  = 2'd0,
    FUNC_DEPART  = 2'd1,
    FUNC_RD_STORE = 2'd2,
    FUNC_RD_RING = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED   = 3'd0,
    STAT_QUEUED   = 3'd1,
    STAT_DROPPED  = 3'd2,
    STAT_REMOVED  = 3'd3,
    STAT_PROMOTED = 3'd4,
    STAT_NOTFOUND = 3'd5,
    STAT_READOK   = 3'd6,
    STAT_READBAD  = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE        = 4'd0,
    OP_LATCH       = 4'd1,
    OP_ARRIVE_STORE = 4'd2,
    OP_ARRIVE_RING = 4'd3,
    OP_SRCH_START  = 4'd4,
    OP_SRCH_NEXT   = 4'd5,
    OP_SHIFT_START = 4'd6,
    OP_SHIFT_STEP  = 4'd7,
    OP_PROMO_RD    = 4'd8,
    OP_PROMO_WR    = 4'd9,
    OP_RD_STORE    = 4'd10,
    OP_RD_RING     = 4'd11
  } dp_op_e;

  typedef enum logic [1:0] {
    DSEL_ZERO  = 2'd0,
    DSEL_ONES  = 2'd1,
    DSEL_STORE = 2'd2,
    DSEL_RING  = 2'd3
  } data_sel_e;

  typedef struct packed {
    dp_op_e    op;
    logic      fill_dec;
    logic      res_we;
    status_e   res_status;
    data_sel_e res_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  fill_lt_cap;
    logic  fill_zero;
    logic  ring_full;
    logic  ring_empty;
    logic  store_pos_ok;
    logic  ring_pos_ok;
    logic  key_match;
    logic  idx_zero;
    logic  nxt1_lt_fill;
    logic  nxt2_lt_fill;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

### src/ordered_store_with_overflow_fifo_core.sv
// Top level of the ordered store with overflow queue.
`default_nettype none
// One item is worked at a time. A successful read waits for the registered RAM
// read before its result is formed. A departure scans the store from the top down
// through the single read port of the store RAM, one entry per cycle, then closes
// the gap with one read and one write per cycle, and may then promote the head of
// the ring into the store. The next item is taken as soon as the result sits in
// the output register.
module ordered_store_with_overflow_fifo_core
  import osf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int unsigned RING_DEPTH  = DEF_RING_DEPTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key[31:0], position[39:32]
  input  wire logic [FUNC_W-1:0]      s_axis_tuser,  // func[1:0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // data[31:0], store_count[38:32],
                                                     // wait_count[44:39], zero[47:45]
  output logic      [STATUS_W-1:0]    m_axis_tuser,  // status[2:0]
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  osf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  osf_dp #(
    .STORE_DEPTH(STORE_DEPTH),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule
`default_nettype wire

### src/osf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module osf_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/osf_ctrl.sv
// Controller state machine: sequences arrive, depart, promotion and reads.
`default_nettype none
module osf_ctrl
  import osf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_SRCH     = 8'b0000_0100,
    S_SHIFT    = 8'b0000_1000,
    S_PROMO    = 8'b0001_0000,
    S_PROMO_WR = 8'b0010_0000,
    S_RDWAIT   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.fill_dec = 1'b0;
    cmd_o.res_we   = 1'b0;
    cmd_o.res_status = STAT_STORED;
    cmd_o.res_sel  = DSEL_ZERO;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.func)
          FUNC_ARRIVE: begin
            cmd_o.res_we = 1'b1;
            state_d      = S_DONE;
            priority if (sts_i.fill_lt_cap) begin
              cmd_o.op         = OP_ARRIVE_STORE;
              cmd_o.res_status = STAT_STORED;
            end else if (!sts_i.ring_full) begin
              cmd_o.op         = OP_ARRIVE_RING;
              cmd_o.res_status = STAT_QUEUED;
            end else begin
              cmd_o.res_status = STAT_DROPPED;
            end
          end
          FUNC_DEPART: begin
            if (sts_i.fill_zero) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = STAT_NOTFOUND;
              state_d          = S_DONE;
            end else begin
              cmd_o.op = OP_SRCH_START;
              state_d  = S_SRCH;
            end
          end
          FUNC_RD_STORE: begin
            if (sts_i.store_pos_ok) begin
              cmd_o.op = OP_RD_STORE;
              state_d  = S_RDWAIT;
            end else begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = STAT_READBAD;
              cmd_o.res_sel    = DSEL_ONES;
              state_d          = S_DONE;
            end
          end
          FUNC_RD_RING: begin
            if (sts_i.ring_pos_ok) begin
              cmd_o.op = OP_RD_RING;
              state_d  = S_RDWAIT;
            end else begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = STAT_READBAD;
              cmd_o.res_sel    = DSEL_ONES;
              state_d          = S_DONE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SRCH: begin
        priority if (sts_i.key_match) begin
          if (sts_i.nxt1_lt_fill) begin
            cmd_o.op = OP_SHIFT_START;
            state_d  = S_SHIFT;
          end else begin
            cmd_o.fill_dec = 1'b1;
            state_d        = S_PROMO;
          end
        end else if (sts_i.idx_zero) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = STAT_NOTFOUND;
          state_d          = S_DONE;
        end else begin
          cmd_o.op = OP_SRCH_NEXT;
        end
      end
      S_SHIFT: begin
        cmd_o.op = OP_SHIFT_STEP;
        if (!sts_i.nxt2_lt_fill) begin
          cmd_o.fill_dec = 1'b1;
          state_d        = S_PROMO;
        end
      end
      S_PROMO: begin
        if (!sts_i.ring_empty && sts_i.fill_lt_cap) begin
          cmd_o.op = OP_PROMO_RD;
          state_d  = S_PROMO_WR;
        end else begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = STAT_REMOVED;
          state_d          = S_DONE;
        end
      end
      S_PROMO_WR: begin
        cmd_o.op         = OP_PROMO_WR;
        cmd_o.res_we     = 1'b1;
        cmd_o.res_status = STAT_PROMOTED;
        state_d          = S_DONE;
      end
      S_RDWAIT: begin
        cmd_o.res_we     = 1'b1;
        cmd_o.res_status = STAT_READOK;
        cmd_o.res_sel    = (sts_i.func == FUNC_RD_STORE) ? DSEL_STORE : DSEL_RING;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### src/osf_dp.sv
// Datapath: store and ring memories, fill and ring pointers, config and result registers.
`default_nettype none
module osf_dp
  import osf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int unsigned RING_DEPTH  = DEF_RING_DEPTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output sts_t                        sts_o,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  input  wire logic [FUNC_W-1:0]      in_user_i,
  input  wire logic                   cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic      [OUT_TDATA_W-1:0] out_data_o,
  output logic      [STATUS_W-1:0]    out_user_o
);

  localparam int unsigned SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned RW  = $clog2(RING_DEPTH);
  localparam int unsigned MW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned PW  = (FW > POS_W) ? FW : POS_W;
  localparam int unsigned QW  = (MW + 1 > POS_W + 1) ? MW + 1 : POS_W + 1;
  localparam int unsigned PAD_W = OUT_TDATA_W - DATA_W - SCOUNT_W - WCOUNT_W;

  func_e               func_q;
  logic [KEY_W-1:0]    key_q;
  logic [POS_W-1:0]    pos_q;
  logic [FW-1:0]       fill_q, fill_d;
  logic [RW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [SAW-1:0]      idx_q;
  logic [CFG_DATA_W-1:0] lot_cap_q, ring_size_q;
  status_e             status_q;
  logic [DATA_W-1:0]   data_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [DATA_W-1:0]   out_data_q;
  logic [SCOUNT_W-1:0] out_scount_q;
  logic [WCOUNT_W-1:0] out_wcount_q;

  logic [FW-1:0]  cap, fill_m1;
  logic [MW-1:0]  m, tail_p1, head_p1;
  logic [RW-1:0]  tail_nx, head_nx, wcount;
  logic [QW-1:0]  qsum, qwrap;
  logic [RW-1:0]  qaddr;
  logic [FW:0]    idx_p1, idx_p2;
  logic [DATA_W-1:0] res_data;

  logic              st_we, st_re, rg_we, rg_re;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [RW-1:0]     rg_waddr, rg_raddr;
  logic [KEY_W-1:0]  st_wdata, rg_wdata, st_rdata, rg_rdata;

  assign cap = (32'(lot_cap_q) > 32'(STORE_DEPTH)) ? FW'(STORE_DEPTH) : FW'(lot_cap_q);
  assign m   = (ring_size_q == '0) ? MW'(1) :
               (32'(ring_size_q) > 32'(RING_DEPTH)) ? MW'(RING_DEPTH) : MW'(ring_size_q);

  assign fill_m1 = fill_q - FW'(1);
  assign tail_p1 = MW'(tail_q) + MW'(1);
  assign head_p1 = MW'(head_q) + MW'(1);
  assign tail_nx = (tail_p1 == m) ? '0 : RW'(tail_p1);
  assign head_nx = (head_p1 == m) ? '0 : RW'(head_p1);
  assign wcount  = (tail_q >= head_q) ? RW'(MW'(tail_q) - MW'(head_q))
                                      : RW'(MW'(tail_q) + m - MW'(head_q));

  assign qsum  = QW'(head_q) + QW'(pos_q) - QW'(1);
  assign qwrap = (qsum >= QW'(m)) ? qsum - QW'(m) : qsum;
  assign qaddr = RW'(qwrap);

  assign idx_p1 = (FW+1)'(idx_q) + (FW+1)'(1);
  assign idx_p2 = (FW+1)'(idx_q) + (FW+1)'(2);

  assign sts_o.func         = func_q;
  assign sts_o.fill_lt_cap  = fill_q < cap;
  assign sts_o.fill_zero    = fill_q == '0;
  assign sts_o.ring_full    = tail_nx == head_q;
  assign sts_o.ring_empty   = tail_q == head_q;
  assign sts_o.store_pos_ok = (pos_q != '0) && (PW'(pos_q) <= PW'(fill_q));
  assign sts_o.ring_pos_ok  = (pos_q != '0) && (QW'(pos_q) <= QW'(wcount));
  assign sts_o.key_match    = st_rdata == key_q;
  assign sts_o.idx_zero     = idx_q == '0;
  assign sts_o.nxt1_lt_fill = idx_p1 < (FW+1)'(fill_q);
  assign sts_o.nxt2_lt_fill = idx_p2 < (FW+1)'(fill_q);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = SAW'(fill_q);
    st_wdata = key_q;
    st_re    = 1'b0;
    st_raddr = idx_q;
    rg_we    = 1'b0;
    rg_waddr = tail_q;
    rg_wdata = key_q;
    rg_re    = 1'b0;
    rg_raddr = head_q;
    unique case (cmd_i.op)
      OP_NONE, OP_LATCH: begin
      end
      OP_ARRIVE_STORE: begin
        st_we = 1'b1;
      end
      OP_ARRIVE_RING: begin
        rg_we = 1'b1;
      end
      OP_SRCH_START: begin
        st_re    = 1'b1;
        st_raddr = SAW'(fill_m1);
      end
      OP_SRCH_NEXT: begin
        st_re    = 1'b1;
        st_raddr = idx_q - SAW'(1);
      end
      OP_SHIFT_START: begin
        st_re    = 1'b1;
        st_raddr = SAW'(idx_p1);
      end
      OP_SHIFT_STEP: begin
        st_we    = 1'b1;
        st_waddr = idx_q;
        st_wdata = st_rdata;
        st_re    = 1'b1;
        st_raddr = SAW'(idx_p2);
      end
      OP_PROMO_RD: begin
        rg_re = 1'b1;
      end
      OP_PROMO_WR: begin
        st_we    = 1'b1;
        st_wdata = rg_rdata;
      end
      OP_RD_STORE: begin
        st_re    = 1'b1;
        st_raddr = SAW'(pos_q - POS_W'(1));
      end
      OP_RD_RING: begin
        rg_re    = 1'b1;
        rg_raddr = qaddr;
      end
      default: begin
      end
    endcase
  end

  osf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STORE_DEPTH),
    .ADDR_W(SAW)
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  osf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (RING_DEPTH),
    .ADDR_W(RW)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (rg_we),
    .waddr_i(rg_waddr),
    .wdata_i(rg_wdata),
    .re_i   (rg_re),
    .raddr_i(rg_raddr),
    .rdata_o(rg_rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.op == OP_ARRIVE_STORE || cmd_i.op == OP_PROMO_WR) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_m1;
    end
  end

  always_comb begin
    tail_d = tail_q;
    head_d = head_q;
    if (cfg_valid_i && cfg_index_i == REG_RING_SIZE) begin
      tail_d = '0;
      head_d = '0;
    end else begin
      if (cmd_i.op == OP_ARRIVE_RING) begin
        tail_d = tail_nx;
      end
      if (cmd_i.op == OP_PROMO_WR) begin
        head_d = head_nx;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.res_sel)
      DSEL_ZERO:  res_data = '0;
      DSEL_ONES:  res_data = '1;
      DSEL_STORE: res_data = st_rdata;
      DSEL_RING:  res_data = rg_rdata;
      default:    res_data = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      lot_cap_q   <= RST_LOT_CAPACITY;
      ring_size_q <= RST_RING_SIZE;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      head_q <= head_d;
      tail_q <= tail_d;
      if (cfg_valid_i && cfg_index_i == REG_LOT_CAPACITY) begin
        lot_cap_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == REG_RING_SIZE) begin
        ring_size_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      func_q <= func_e'(in_user_i);
      key_q  <= in_data_i[KEY_W-1:0];
      pos_q  <= in_data_i[KEY_W +: POS_W];
    end
    if (cmd_i.op == OP_SRCH_START) begin
      idx_q <= SAW'(fill_m1);
    end else if (cmd_i.op == OP_SRCH_NEXT) begin
      idx_q <= idx_q - SAW'(1);
    end else if (cmd_i.op == OP_SHIFT_STEP) begin
      idx_q <= SAW'(idx_p1);
    end
    if (cmd_i.res_we) begin
      status_q <= cmd_i.res_status;
      data_q   <= res_data;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_data_q   <= data_q;
      out_scount_q <= SCOUNT_W'(fill_q);
      out_wcount_q <= WCOUNT_W'(wcount);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_status_q;
  assign out_data_o  = {{PAD_W{1'b0}}, out_wcount_q, out_scount_q, out_data_q};

endmodule
`default_nettype wire
